// File: hdl/ctc_pkg.sv
package ctc_pkg;

	localparam int CHAR_W     = 8;
	localparam int COL_W      = 4;
	localparam int KEY_W      = 24;
	localparam int SLOT_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = KEY_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t PAD_CHAR   = 8'h7a;
	localparam char_t SPACE_CHAR = 8'h20;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ORDER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

	localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 4'd4;
	localparam logic [KEY_W-1:0] KEY_ORDER_RST    = 24'd16434824;
	localparam logic             DECRYPT_MODE_RST = 1'b0;

	typedef struct packed {
		logic              decrypt_mode;
		logic [KEY_W-1:0]  key_order;
		logic [COL_W-1:0]  column_count;
	} cfg_t;

	typedef struct packed {
		logic  cmd;
		char_t ch;
	} op_t;

	typedef struct packed {
		logic push;
		op_t  op;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_rd_t;

	function automatic logic [SLOT_W-1:0] key_slot(logic [KEY_W-1:0] key,
			logic [SLOT_W-1:0] i);
		return key[SLOT_W*i +: SLOT_W];
	endfunction

endpackage

// File: hdl/ctc_msg_if.sv
interface ctc_msg_if;
	logic            valid;
	logic            ready;
	logic            command;
	ctc_pkg::char_t  char_in;

	modport source(output valid, command, char_in, input ready);
	modport sink(input valid, command, char_in, output ready);
endinterface

// File: hdl/ctc_res_if.sv
interface ctc_res_if;
	logic            valid;
	logic            ready;
	ctc_pkg::char_t  char_out;
	logic            last_char;
	logic            overflow;

	modport source(output valid, char_out, last_char, overflow, input ready);
	modport sink(input valid, char_out, last_char, overflow, output ready);
endinterface

// File: hdl/ctc_cfg_if.sv
interface ctc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ctc_pkg::CFG_IDX_W-1:0]     index;
	logic [ctc_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/columnar_transposition_cipher.sv
// Columnar transposition cipher. Each load transaction stores one character
// (spaces are dropped) at one per cycle while the back end is idle; an end
// transaction pads the last row with 'z' and streams the whole grid out,
// columns in key order for encrypt or rows restored for decrypt, with
// last_char on the final character and overflow set when characters were
// dropped for capacity. An end runs the bit-serial row-count divider, then
// streams one character per cycle, unless the result side stalls, out of the
// buffer's single read port via the read and output registers. A four-entry
// queue sits between the input classifier and the executing back end, so
// loads keep arriving while a message is still being emitted. Configuration
// writes are always taken and must only be issued while the block is idle.
module columnar_transposition_cipher #(
	parameter int MAX_CHARS   = 64,
	parameter int MAX_COLUMNS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ctc_msg_if.sink    msg,
	ctc_res_if.source  res,
	ctc_cfg_if.sink    cfg
);

	ctc_pkg::cfg_t   cfg_q;
	ctc_pkg::q_wr_t  q_wr;
	ctc_pkg::q_rd_t  q_rd;
	logic            q_full;
	logic            pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_count <= ctc_pkg::COLUMN_COUNT_RST;
			cfg_q.key_order    <= ctc_pkg::KEY_ORDER_RST;
			cfg_q.decrypt_mode <= ctc_pkg::DECRYPT_MODE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ctc_pkg::REG_COLUMN_COUNT: cfg_q.column_count <= cfg.data[ctc_pkg::COL_W-1:0];
				ctc_pkg::REG_KEY_ORDER:    cfg_q.key_order    <= cfg.data[ctc_pkg::KEY_W-1:0];
				ctc_pkg::REG_DECRYPT_MODE: cfg_q.decrypt_mode <= cfg.data[0];
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	ctc_front u_front (
		.msg    (msg),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	ctc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	ctc_back #(
		.MAX_CHARS   (MAX_CHARS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_rd   (q_rd),
		.pop    (pop),
		.res    (res)
	);

endmodule

// File: hdl/ctc_front.sv
module ctc_front (
	ctc_msg_if.sink         msg,
	input  logic            q_full,
	output ctc_pkg::q_wr_t  q_wr
);

	logic keep;

	// spaces are dropped before they reach the queue
	assign keep = !(msg.command == ctc_pkg::CMD_LOAD && msg.char_in == ctc_pkg::SPACE_CHAR);

	assign msg.ready    = !q_full;
	assign q_wr.push    = msg.valid && !q_full && keep;
	assign q_wr.op.cmd  = msg.command;
	assign q_wr.op.ch   = msg.char_in;

endmodule

// File: hdl/ctc_queue.sv
module ctc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  ctc_pkg::q_wr_t  q_wr,
	output logic            q_full,
	input  logic            pop,
	output ctc_pkg::q_rd_t  q_rd
);

	localparam int PW = ctc_pkg::QPTR_W;
	localparam int NW = $clog2(ctc_pkg::QUEUE_DEPTH + 1);

	ctc_pkg::op_t    slots_q [ctc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign q_full   = fill_q == NW'(ctc_pkg::QUEUE_DEPTH);
	assign do_push  = q_wr.push && !q_full;
	assign do_pop   = pop && fill_q != '0;
	assign q_rd.valid = fill_q != '0;
	assign q_rd.op    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= q_wr.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + NW'(1);
				2'b01:   fill_q <= fill_q - NW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: hdl/ctc_back.sv
module ctc_back #(
	parameter int MAX_CHARS   = 64,
	parameter int MAX_COLUMNS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ctc_pkg::cfg_t   cfg,
	input  ctc_pkg::q_rd_t  q_rd,
	output logic            pop,
	ctc_res_if.source       res
);

	localparam int AW    = $clog2(MAX_CHARS);
	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam int IW    = $clog2(MAX_CHARS + MAX_COLUMNS);
	localparam int CSW   = $clog2(MAX_COLUMNS);
	localparam int CW    = ctc_pkg::COL_W;
	localparam int SW    = ctc_pkg::SLOT_W;
	localparam int DCW   = $clog2(IW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	ctc_pkg::char_t     buf_q [MAX_CHARS];
	logic [CNT_W-1:0]   cnt_q;
	logic               drop_q;
	logic [IW-1:0]      div_q;
	logic [CW-1:0]      rem_q;
	logic [DCW-1:0]     dcnt_q;
	logic [CNT_W-1:0]   rows_q;
	logic [CNT_W-1:0]   outer_q;
	logic [CNT_W-1:0]   inner_q;

	ctc_pkg::char_t     rd_s1;
	logic               valid_s1;
	logic               pad_s1;
	logic               last_s1;
	logic               ovf_s1;

	logic               out_valid_q;
	ctc_pkg::char_t     out_char_q;
	logic               out_last_q;
	logic               out_ovf_q;

	logic [CNT_W-1:0]   cap_tab [MAX_COLUMNS];
	logic [CW-1:0]      ncol;
	logic [CW-1:0]      ncol_m1;
	logic [CNT_W-1:0]   cap;
	logic [CNT_W-1:0]   cnt_eff;
	logic [IW-1:0]      dividend;
	logic [CW:0]        rem_next;
	logic [CW:0]        rem_sub;
	logic               q_bit;
	logic [IW-1:0]      q_next;

	logic [SW-1:0]      enc_col;
	logic [SW-1:0]      dec_slot;
	logic               dec_found;
	logic [IW-1:0]      addr;
	logic               pad;
	logic               last;
	logic               inner_wrap;
	logic               cell_ok;
	logic [CNT_W-1:0]   rows_m1;
	logic [CNT_W-1:0]   ncol_m1w;

	logic               out_free;
	logic               s1_move;
	logic               adv;
	logic               wr_en;

	for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cap
		localparam int Ncol = g + 1;
		localparam int Cap  = (MAX_CHARS / Ncol) * Ncol;
		assign cap_tab[g] = CNT_W'(Cap);
	end

	always_comb begin
		if (cfg.column_count == '0) begin
			ncol = CW'(1);
		end else if (cfg.column_count > CW'(MAX_COLUMNS)) begin
			ncol = CW'(MAX_COLUMNS);
		end else begin
			ncol = cfg.column_count;
		end
	end

	assign ncol_m1  = ncol - CW'(1);
	assign cap      = cap_tab[ncol_m1[CSW-1:0]];
	assign cnt_eff  = (cnt_q > cap) ? cap : cnt_q;
	assign dividend = IW'(cnt_eff) + IW'(ncol) - IW'(1);

	// restoring division for the row count, one quotient bit per cycle
	assign rem_next = {rem_q, div_q[IW-1]};
	assign rem_sub  = rem_next - {1'b0, ncol};
	assign q_bit    = rem_next >= {1'b0, ncol};
	assign q_next   = {div_q[IW-2:0], q_bit};

	assign rows_m1  = rows_q - CNT_W'(1);
	assign ncol_m1w = CNT_W'(ncol) - CNT_W'(1);
	assign enc_col  = ctc_pkg::key_slot(cfg.key_order, outer_q[SW-1:0]);

	// lowest slot in use that names the current column
	always_comb begin
		dec_found = 1'b0;
		dec_slot  = '0;
		for (int i = 0; i < 8; i++) begin
			if (!dec_found && CW'(i) < ncol
					&& ctc_pkg::key_slot(cfg.key_order, SW'(i)) == inner_q[SW-1:0]) begin
				dec_found = 1'b1;
				dec_slot  = SW'(i);
			end
		end
	end

	always_comb begin
		if (cfg.decrypt_mode) begin
			pad        = !dec_found;
			addr       = IW'(IW'(dec_slot) * IW'(rows_q)) + IW'(outer_q);
			inner_wrap = inner_q == ncol_m1w;
			last       = outer_q == rows_m1 && inner_wrap;
		end else begin
			pad        = CW'(enc_col) >= ncol;
			addr       = IW'(IW'(inner_q) * IW'(ncol)) + IW'(enc_col);
			inner_wrap = inner_q == rows_m1;
			last       = outer_q == ncol_m1w && inner_wrap;
		end
	end

	assign cell_ok  = !pad && addr < IW'(cnt_q);
	assign out_free = !out_valid_q || res.ready;
	assign s1_move  = valid_s1 && out_free;
	assign adv      = state_q == ST_EMIT && (!valid_s1 || out_free);
	assign pop      = state_q == ST_IDLE && q_rd.valid;
	assign wr_en    = pop && q_rd.op.cmd == ctc_pkg::CMD_LOAD && cnt_q < cap;

	assign res.valid     = out_valid_q;
	assign res.char_out  = out_char_q;
	assign res.last_char = out_last_q;
	assign res.overflow  = out_ovf_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[cnt_q[AW-1:0]] <= q_rd.op.ch;
		end
		if (adv) begin
			rd_s1 <= buf_q[addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			div_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			rows_q      <= '0;
			outer_q     <= '0;
			inner_q     <= '0;
			valid_s1    <= 1'b0;
			pad_s1      <= 1'b0;
			last_s1     <= 1'b0;
			ovf_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_rd.valid) begin
						if (q_rd.op.cmd == ctc_pkg::CMD_END) begin
							if (cnt_q > cap) begin
								cnt_q  <= cap;
								drop_q <= 1'b1;
							end
							div_q   <= dividend;
							rem_q   <= '0;
							dcnt_q  <= DCW'(IW - 1);
							state_q <= ST_DIV;
						end else if (cnt_q >= cap) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_DIV: begin
					div_q <= q_next;
					rem_q <= q_bit ? rem_sub[CW-1:0] : rem_next[CW-1:0];
					if (dcnt_q == '0) begin
						rows_q  <= q_next[CNT_W-1:0];
						outer_q <= '0;
						inner_q <= '0;
						if (q_next == '0) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						dcnt_q <= dcnt_q - DCW'(1);
					end
				end
				ST_EMIT: begin
					if (adv) begin
						if (last) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else if (inner_wrap) begin
							inner_q <= '0;
							outer_q <= outer_q + CNT_W'(1);
						end else begin
							inner_q <= inner_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (adv) begin
				valid_s1 <= 1'b1;
				pad_s1   <= !cell_ok;
				last_s1  <= last;
				ovf_s1   <= drop_q;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
				out_char_q  <= pad_s1 ? ctc_pkg::PAD_CHAR : rd_s1;
				out_last_q  <= last_s1;
				out_ovf_q   <= ovf_s1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sim/columnar_transposition_cipher_tb.sv
module columnar_transposition_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctc_pkg::*;

	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 4;
	localparam int SETTLE_CYCLES = 40;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int BUF_CHARS     = 64;
	localparam int BUF_COLS      = 8;

	typedef struct packed {
		char_t ch;
		logic  last;
		logic  ovf;
	} cipher_char_t;

	logic clk;
	logic arst_n;

	ctc_msg_if msg_if();
	ctc_res_if res_if();
	ctc_cfg_if cfg_if();

	columnar_transposition_cipher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	char_t            grid_buf [BUF_CHARS];
	int unsigned      grid_fill;
	logic             grid_dropped;
	logic [COL_W-1:0] cfg_cols;
	logic [KEY_W-1:0] cfg_key;
	logic             cfg_decrypt;

	op_t          pending_ops [$];
	cipher_char_t expected_chars [$];

	int src_idle_pct;
	int snk_idle_pct;
	int mismatch_count;
	int sent_count;
	int queued_count;
	int checked_count;
	int settings_count;

	op_t          drv_op;
	cipher_char_t mon_want;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned clamp_cols(logic [COL_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > BUF_COLS)
			return BUF_COLS;
		return 32'(c);
	endfunction

	function automatic int unsigned key_col(int unsigned i);
		return 32'(cfg_key[SLOT_W*i +: SLOT_W]);
	endfunction

	function automatic char_t grid_cell(int unsigned idx);
		return (idx < grid_fill) ? grid_buf[idx] : PAD_CHAR;
	endfunction

	function automatic void add_expected(char_t v, logic last);
		cipher_char_t e;
		e.ch   = v;
		e.last = last;
		e.ovf  = grid_dropped;
		expected_chars.insert(expected_chars.size(), e);
	endfunction

	function automatic void cipher_step(op_t op);
		int unsigned n;
		int unsigned cap;
		int unsigned rows;
		int unsigned total;
		int unsigned k;
		int unsigned col;
		char_t       v;
		logic        found;
		n   = clamp_cols(cfg_cols);
		cap = (BUF_CHARS / n) * n;
		if (op.cmd == CMD_LOAD) begin
			if (op.ch == SPACE_CHAR)
				return;
			if (grid_fill >= cap) begin
				grid_dropped = 1'b1;
				return;
			end
			grid_buf[grid_fill] = op.ch;
			grid_fill++;
			return;
		end
		if (grid_fill > cap) begin
			grid_fill    = cap;
			grid_dropped = 1'b1;
		end
		rows  = (grid_fill + n - 1) / n;
		total = rows * n;
		k     = 0;
		if (!cfg_decrypt) begin
			for (int unsigned i = 0; i < n; i++) begin
				col = key_col(i);
				for (int unsigned r = 0; r < rows; r++) begin
					v = (col < n) ? grid_cell(r * n + col) : PAD_CHAR;
					k++;
					add_expected(v, k == total);
				end
			end
		end else begin
			for (int unsigned r = 0; r < rows; r++) begin
				for (int unsigned c = 0; c < n; c++) begin
					v     = PAD_CHAR;
					found = 1'b0;
					for (int unsigned i = 0; i < n; i++) begin
						if (!found && key_col(i) == c) begin
							v     = grid_cell(i * rows + r);
							found = 1'b1;
						end
					end
					k++;
					add_expected(v, k == total);
				end
			end
		end
		grid_fill    = 0;
		grid_dropped = 1'b0;
	endfunction

	function automatic logic [KEY_W-1:0] make_perm_key(int unsigned n);
		logic [SLOT_W-1:0] slots [BUF_COLS];
		logic [SLOT_W-1:0] t;
		logic [KEY_W-1:0]  k;
		int unsigned       j;
		k = KEY_W'($urandom);
		for (int i = 0; i < BUF_COLS; i++)
			slots[i] = SLOT_W'(i);
		for (int i = n - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			t        = slots[i];
			slots[i] = slots[j];
			slots[j] = t;
		end
		for (int i = 0; i < n; i++)
			k[SLOT_W*i +: SLOT_W] = slots[i];
		return k;
	endfunction

	// message driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg_if.valid && msg_if.ready) begin
				cipher_step('{cmd: msg_if.command, ch: msg_if.char_in});
				sent_count++;
			end
			if (!msg_if.valid || msg_if.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					drv_op = pending_ops.pop_front();
					msg_if.valid   <= 1'b1;
					msg_if.command <= drv_op.cmd;
					msg_if.char_in <= drv_op.ch;
				end else begin
					msg_if.valid   <= 1'b0;
					msg_if.command <= 1'($urandom);
					msg_if.char_in <= CHAR_W'($urandom);
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				checked_count++;
				if (expected_chars.size() == 0) begin
					$error("unexpected transaction: char_out %02h", res_if.char_out);
					mismatch_count++;
				end else begin
					mon_want = expected_chars.pop_front();
					if (res_if.char_out !== mon_want.ch) begin
						$error("char_out: expected %02h, actual %02h", mon_want.ch,
							res_if.char_out);
						mismatch_count++;
					end
					if (res_if.last_char !== mon_want.last) begin
						$error("last_char: expected %0b, actual %0b", mon_want.last,
							res_if.last_char);
						mismatch_count++;
					end
					if (res_if.overflow !== mon_want.ovf) begin
						$error("overflow: expected %0b, actual %0b", mon_want.ovf,
							res_if.overflow);
						mismatch_count++;
					end
				end
			end
			res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic push_op(logic cmd, char_t ch);
		op_t op;
		op.cmd = cmd;
		op.ch  = ch;
		pending_ops.insert(pending_ops.size(), op);
		queued_count++;
	endtask

	task automatic add_message(int chars, int space_pct);
		char_t ch;
		for (int j = 0; j < chars; j++) begin
			ch = CHAR_W'($urandom);
			if ($urandom_range(99) < space_pct)
				ch = SPACE_CHAR;
			else if (ch == SPACE_CHAR)
				ch = 8'h21;
			push_op(CMD_LOAD, ch);
		end
		push_op(CMD_END, CHAR_W'($urandom));
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_ops.size() != 0 || msg_if.valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// called at a rising edge, returns at the edge that took the write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			REG_COLUMN_COUNT: cfg_cols    = val[COL_W-1:0];
			REG_KEY_ORDER:    cfg_key     = val[KEY_W-1:0];
			REG_DECRYPT_MODE: cfg_decrypt = val[0];
			default: ;
		endcase
	endtask

	task automatic write_config(logic [COL_W-1:0] cols, logic [KEY_W-1:0] key, logic dec);
		write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(cols));
		write_reg(REG_KEY_ORDER, key);
		write_reg(REG_DECRYPT_MODE, CFG_DATA_W'(dec));
		cfg_if.valid <= 1'b0;
		settings_count++;
	endtask

	task automatic run_phase(int p, logic [COL_W-1:0] cols, logic [KEY_W-1:0] key,
			logic dec);
		int   start;
		int   pick;
		logic paused;
		wait_drained();
		if (p < 4) begin
			src_idle_pct = 27;
			snk_idle_pct = 52;
		end else if (p < 7) begin
			src_idle_pct = 52;
			snk_idle_pct = 27;
		end else begin
			src_idle_pct = 0;
			snk_idle_pct = 0;
		end
		write_config(cols, key, dec);
		start  = queued_count;
		paused = 1'b0;
		if (p == 4)
			add_message(BUF_CHARS + $urandom_range(1, 3), 0);
		if (p == 6) begin
			// fill past six columns' capacity at eight, then end at six so the grid gets cut
			for (int j = 0; j < BUF_CHARS - 3; j++)
				push_op(CMD_LOAD, 8'h41 + CHAR_W'(j[5:0]));
			wait_drained();
			write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(6));
			cfg_if.valid <= 1'b0;
			push_op(CMD_END, CHAR_W'($urandom));
			start = queued_count;
		end
		while (queued_count - start < PHASE_ITEMS) begin
			pick = $urandom_range(9);
			if (pick == 0)
				push_op(CMD_END, CHAR_W'($urandom));
			else if (pick == 1)
				add_message($urandom_range(1, 3), 100);
			else if (pick == 2)
				add_message($urandom_range(12, 20), 15);
			else
				add_message($urandom_range(1, 10), 12);
			if (!paused && queued_count - start >= PHASE_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		logic [COL_W-1:0] cols;
		logic [KEY_W-1:0] key;
		logic             dec;
		msg_if.valid   = 1'b0;
		msg_if.command = CMD_LOAD;
		msg_if.char_in = '0;
		res_if.ready   = 1'b0;
		cfg_if.valid   = 1'b0;
		cfg_if.index   = '0;
		cfg_if.data    = '0;
		arst_n         = 1'b0;
		src_idle_pct   = 27;
		snk_idle_pct   = 52;
		mismatch_count = 0;
		sent_count     = 0;
		queued_count   = 0;
		checked_count  = 0;
		settings_count = 1;
		grid_fill      = 0;
		grid_dropped   = 1'b0;
		cfg_cols       = COLUMN_COUNT_RST;
		cfg_key        = KEY_ORDER_RST;
		cfg_decrypt    = DECRYPT_MODE_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// end on an empty grid, then a ragged message with extreme bytes
		push_op(CMD_END, 8'h00);
		push_op(CMD_LOAD, 8'h41);
		push_op(CMD_LOAD, 8'h42);
		push_op(CMD_LOAD, SPACE_CHAR);
		push_op(CMD_LOAD, 8'h43);
		push_op(CMD_LOAD, 8'h00);
		push_op(CMD_LOAD, 8'hff);
		push_op(CMD_LOAD, PAD_CHAR);
		push_op(CMD_LOAD, 8'h80);
		push_op(CMD_LOAD, 8'h7f);
		push_op(CMD_LOAD, 8'h55);
		push_op(CMD_LOAD, 8'haa);
		push_op(CMD_END, 8'hff);
		// only a space, so nothing comes out
		push_op(CMD_LOAD, SPACE_CHAR);
		push_op(CMD_END, SPACE_CHAR);
		// one full row
		push_op(CMD_LOAD, 8'h01);
		push_op(CMD_LOAD, 8'h02);
		push_op(CMD_LOAD, 8'h04);
		push_op(CMD_LOAD, 8'h08);
		push_op(CMD_END, 8'h00);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					cols = 1;
					key  = make_perm_key(1);
					dec  = 1'b0;
				end
				1: begin
					cols = 8;
					key  = make_perm_key(8);
					dec  = 1'b1;
				end
				2: begin
					cols = 4;
					key  = 24'hffffff;
					dec  = 1'b0;
				end
				3: begin
					cols = 0;
					key  = KEY_W'($urandom);
					dec  = 1'b1;
				end
				4: begin
					cols = 15;
					key  = make_perm_key(8);
					dec  = 1'b0;
				end
				5: begin
					cols = 3;
					key  = 24'h000000;
					dec  = 1'b1;
				end
				6: begin
					cols = 8;
					key  = make_perm_key(8);
					dec  = 1'b0;
				end
				default: begin
					cols = COL_W'($urandom_range(15));
					key  = $urandom_range(1) ? make_perm_key(clamp_cols(cols))
						: KEY_W'($urandom);
					dec  = 1'($urandom_range(1));
				end
			endcase
			run_phase(p, cols, key, dec);
		end
		wait_drained();

		$display("%0d message transactions over %0d register settings, %0d characters checked",
			sent_count, settings_count, checked_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
